// ===== hw/rtl/kti_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Keyframe tween interpolator package
// Shared widths, codes and word types for the tween unit and its sub-units.
// ---------------------------------------------------------------------------
package kti_pkg;

  // Fraction bits of the curve parameter t and of the easing factor.
  localparam int FRAC_BITS = 16;

  localparam int FRAME_W = 16;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 16;

  // t and the easing factor run from 0 to one inclusive.
  localparam int T_W  = FRAC_BITS + 1;
  // Multiplier operands reach two, so they carry one more bit.
  localparam int OP_W = FRAC_BITS + 2;
  // Signed multiplicand: covers the 33-bit difference and an easing operand.
  localparam int MCAND_W = (FRAC_BITS + 3 > VALUE_W + 1) ? FRAC_BITS + 3 : VALUE_W + 1;
  localparam int PROD_W  = MCAND_W + OP_W;

  localparam int DIV_CNT_W = $clog2(FRAC_BITS);
  localparam int MUL_CNT_W = $clog2(OP_W);

  localparam logic [OP_W-1:0] ONE_OP = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic [OP_W-1:0] TWO_OP = {2'b10, {FRAC_BITS{1'b0}}};

  // Request codes.
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_INTERP  = 1'b1;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_MIN_FRAME   = 2'd0;
  localparam cfg_idx_t REG_MAX_FRAME   = 2'd1;
  localparam cfg_idx_t REG_EASING_MODE = 2'd2;

  typedef enum logic [1:0] {
    EASE_LINEAR = 2'd0,
    EASE_IN     = 2'd1,
    EASE_OUT    = 2'd2,
    EASE_IN_OUT = 2'd3
  } ease_mode_t;

  // How the easing product is turned into the factor.
  typedef enum logic [1:0] {
    POST_SHIFT,
    POST_HALF,
    POST_UPPER
  } post_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_EASE,
    ST_LAUNCH,
    ST_SCALE,
    ST_OUT
  } kti_state_t;

  typedef struct packed {
    logic                      req_type;
    logic signed [VALUE_W-1:0] start_value;
    logic signed [VALUE_W-1:0] end_value;
    logic                      last_of_frame;
  } kti_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [FRAME_W-1:0]        frame;
    logic                      last;
  } kti_out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/kti_divider.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Serial fraction divider
// Restoring division of frame / max_frame, one quotient bit per cycle.
// The dividend must be below the divisor, so the quotient is a pure fraction.
// ---------------------------------------------------------------------------
module kti_divider import kti_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [FRAME_W-1:0]   dividend,
  input  wire logic [FRAME_W-1:0]   divisor,
  output logic                      done,
  output logic [FRAC_BITS-1:0]      quotient
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_BITS - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FRAME_W-1:0]   rem_r, rem_nxt;
  logic [FRAME_W-1:0]   div_r, div_nxt;
  logic [FRAC_BITS-1:0] quot_r, quot_nxt;

  logic [FRAME_W:0] shifted;
  logic [FRAME_W:0] diff;
  logic             fits;

  // One restoring step: double the remainder and try the divisor.
  always_comb begin
    shifted = {rem_r, 1'b0};
    diff    = shifted - {1'b0, div_r};
    fits    = (shifted >= {1'b0, div_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend;
      div_nxt  = divisor;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[FRAME_W-1:0] : shifted[FRAME_W-1:0];
      quot_nxt = {quot_r[FRAC_BITS-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule
`default_nettype wire

// ===== hw/rtl/kti_serial_mult.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle,
// least significant bit first.
// ---------------------------------------------------------------------------
module kti_serial_mult import kti_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [MCAND_W-1:0] mcand,
  input  wire logic [OP_W-1:0]           mplier,
  output logic                           done,
  output logic signed [PROD_W-1:0]       product
);

  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(OP_W - 1);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [MUL_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [MCAND_W-1:0] mcand_r, mcand_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;

  logic [MCAND_W-1:0] hi;
  logic [MCAND_W-1:0] addend;
  logic [MCAND_W:0]   sum;

  // Add the multiplicand into the upper half when the low bit is set,
  // then shift the whole product right by one.
  always_comb begin
    hi     = prod_r[PROD_W-1:OP_W];
    addend = prod_r[0] ? mcand_r : '0;
    sum    = {hi[MCAND_W-1], hi} + {addend[MCAND_W-1], addend};
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      mcand_nxt = mcand;
      prod_nxt  = {{MCAND_W{1'b0}}, mplier};
    end else if (busy_r) begin
      prod_nxt = {sum, prod_r[OP_W-1:1]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == MUL_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    prod_r  <= prod_nxt;
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule
`default_nettype wire

// ===== hw/rtl/keyframe_tween_interpolator_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Keyframe tween interpolator
// Frame counter, serial t = frame/max_frame, easing curve and serial scaling
// of (end - start), giving one interpolated Q16.16 component per word.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : request words (restart, or interpolate one component). One word
//           is in work at a time; in_ready is high only while idle.
//   out_* : one result word per request, held in an output register until
//           taken, so a stalled receiver only delays the next request.
//   cfg_* : register writes (min_frame, max_frame, easing_mode), always
//           ready; write only while no request is in flight.
// A restart goes straight to the output register. An interpolation runs the
// bit-serial divider (one quotient bit a cycle), then, for an easing curve,
// one pass of the shared shift-add multiplier for the easing factor, and
// last a scaling pass (one multiplier bit a cycle); the linear curve takes
// the scaling pass only. A saturated t (frame at or beyond max_frame) skips
// the divider. The next request can be taken at the same edge as the first
// chance to take the result.
// Reset (rst_n low, synchronous) loads the register defaults, clears the
// frame counter and empties the output register.
// ---------------------------------------------------------------------------
module keyframe_tween_interpolator_unit import kti_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire kti_in_t            in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output kti_out_t                out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire cfg_idx_t           cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  kti_state_t state_r, state_nxt;

  // Configuration and frame state.
  logic [FRAME_W-1:0] min_frame_r;
  logic [FRAME_W-1:0] max_frame_r;
  ease_mode_t         mode_r;
  logic [FRAME_W-1:0] counter_r;

  // Per-word working registers.
  logic signed [VALUE_W-1:0] start_r;
  logic signed [VALUE_W:0]   delta_r;
  logic [FRAME_W-1:0]        frame_r;
  logic                      last_r;
  logic [T_W-1:0]            t_r;
  logic [T_W-1:0]            f_r;
  post_t                     post_r, post_sel;
  logic signed [VALUE_W-1:0] res_r;

  logic     out_valid_r;
  kti_out_t out_word_r;

  // Handshake and control.
  logic in_acc, cfg_acc, out_load, saturate;
  logic div_start, div_done;
  logic [FRAC_BITS-1:0] quotient;
  logic mul_start, mul_done, mul_scale;
  logic signed [MCAND_W-1:0] mul_mcand;
  logic [OP_W-1:0]           mul_mplier;
  logic signed [PROD_W-1:0]  mul_product;

  // Easing operands and product post-processing.
  logic [OP_W-1:0] t_op, u_op, v_op, ease_a, ease_b;
  logic            u_low;
  logic [PROD_W-1:0] prod_u;
  logic [OP_W-1:0] sh_f, sh_f1, f_raw, f_clamp;
  logic [OP_W:0]   upper_sum;
  logic [VALUE_W-1:0] scaled;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign saturate  = (max_frame_r == '0) || (counter_r >= max_frame_r);

  // Easing operand selection from t.
  always_comb begin
    t_op     = {1'b0, t_r};
    u_op     = {t_r, 1'b0};
    u_low    = (u_op < ONE_OP);
    v_op     = u_op - ONE_OP;
    ease_a   = t_op;
    ease_b   = t_op;
    post_sel = POST_SHIFT;
    case (mode_r)
      EASE_IN: begin
        ease_a = t_op;
        ease_b = t_op;
      end
      EASE_OUT: begin
        ease_a = t_op;
        ease_b = TWO_OP - t_op;
      end
      EASE_IN_OUT: begin
        if (u_low) begin
          ease_a   = u_op;
          ease_b   = u_op;
          post_sel = POST_HALF;
        end else begin
          ease_a   = v_op;
          ease_b   = TWO_OP - v_op;
          post_sel = POST_UPPER;
        end
      end
      default: begin
        ease_a = t_op;
        ease_b = t_op;
      end
    endcase
  end

  // Shared multiplier input: easing product or the final scaling.
  always_comb begin
    if (mul_scale) begin
      mul_mcand  = MCAND_W'(delta_r);
      mul_mplier = {1'b0, f_r};
    end else begin
      mul_mcand  = MCAND_W'(ease_b);
      mul_mplier = ease_a;
    end
  end

  // Turn the easing product into the factor, clamped to one.
  always_comb begin
    prod_u    = mul_product;
    sh_f      = prod_u[FRAC_BITS +: OP_W];
    sh_f1     = prod_u[FRAC_BITS + 1 +: OP_W];
    upper_sum = {1'b0, ONE_OP} + {1'b0, sh_f};
    case (post_r)
      POST_HALF:  f_raw = sh_f1;
      POST_UPPER: f_raw = upper_sum[OP_W:1];
      default:    f_raw = sh_f;
    endcase
    f_clamp = (f_raw > ONE_OP) ? ONE_OP : f_raw;
    // Floor shift of the signed product, low word only.
    scaled  = prod_u[FRAC_BITS +: VALUE_W];
  end

  // Sequencer: next state and unit starts.
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_scale = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word.req_type == REQ_RESTART) begin
            state_nxt = ST_OUT;
          end else if (saturate) begin
            state_nxt = ST_PREP;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (mode_r == EASE_LINEAR) begin
          state_nxt = ST_LAUNCH;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_EASE;
        end
      end
      ST_EASE: begin
        if (mul_done) begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        mul_scale = 1'b1;
        mul_start = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (mul_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers and the frame counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_frame_r <= '0;
      max_frame_r <= FRAME_W'(60);
      mode_r      <= EASE_LINEAR;
      counter_r   <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          REG_MIN_FRAME:   min_frame_r <= cfg_data[FRAME_W-1:0];
          REG_MAX_FRAME:   max_frame_r <= cfg_data[FRAME_W-1:0];
          REG_EASING_MODE: mode_r      <= ease_mode_t'(cfg_data[1:0]);
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        if (in_word.req_type == REQ_RESTART) begin
          counter_r <= min_frame_r;
        end else if (in_word.last_of_frame) begin
          counter_r <= (counter_r < max_frame_r) ? counter_r + 1'b1 : min_frame_r;
        end
      end
    end
  end

  // Working registers of the word in flight.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      start_r <= in_word.start_value;
      delta_r <= {in_word.end_value[VALUE_W-1], in_word.end_value}
               - {in_word.start_value[VALUE_W-1], in_word.start_value};
      last_r  <= in_word.last_of_frame;
      if (in_word.req_type == REQ_RESTART) begin
        frame_r <= min_frame_r;
        res_r   <= '0;
      end else begin
        frame_r <= counter_r;
        t_r     <= {1'b1, {FRAC_BITS{1'b0}}};
      end
    end
    if (state_r == ST_DIV && div_done) begin
      t_r <= {1'b0, quotient};
    end
    if (state_r == ST_PREP) begin
      post_r <= post_sel;
      if (mode_r == EASE_LINEAR) begin
        f_r <= t_r;
      end
    end
    if (state_r == ST_EASE && mul_done) begin
      f_r <= f_clamp[T_W-1:0];
    end
    if (state_r == ST_SCALE && mul_done) begin
      res_r <= start_r + $signed(scaled);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.value <= res_r;
      out_word_r.frame <= frame_r;
      out_word_r.last  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  kti_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (counter_r),
    .divisor  (max_frame_r),
    .done     (div_done),
    .quotient (quotient)
  );

  kti_serial_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_product)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/kti_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Tween unit port checker
// Watches the top-level ports for ordering and result-register behavior.
// ---------------------------------------------------------------------------
module kti_checker import kti_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire kti_in_t          in_word,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire kti_out_t         out_word
);

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // One request in flight: the unit is busy right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while busy");

  // A new result appears only after the unit was busy.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word without a request");

  // A restart into an empty output register answers zero, through the ST_OUT state into the output register.
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_word.req_type == REQ_RESTART) && !out_valid
      |-> ##2 (out_valid && (out_word.value == '0)))
    else $error("restart result missing or nonzero");

endmodule

bind keyframe_tween_interpolator_unit kti_checker u_kti_checker (.*);
`default_nettype wire

// ===== tb/keyframe_tween_interpolator_unit_test.sv =====
// ---------------------------------------------------------------------------
// Keyframe tween interpolator testbench
// Drives request words and register writes into the tween unit, predicts every
// result word from a model of the frame counter and easing math kept here, and
// compares the unit's results in order. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module keyframe_tween_interpolator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kti_pkg::*;

  // Index past the end of the register list; writes to it are ignored.
  localparam cfg_idx_t REG_NONE = 2'd3;

  localparam logic [63:0] ONE_Q          = 64'd1 << FRAC_BITS;
  localparam int          ITEM_TARGET    = 1650;
  localparam int          SETTLE_CYCLES  = 64;
  localparam int          WATCHDOG_LIMIT = 2000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  kti_in_t              in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  kti_out_t             out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_idx_t             cfg_index = REG_MIN_FRAME;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Predicted unit state and registers.
  logic [FRAME_W-1:0]   tween_frame;
  logic [FRAME_W-1:0]   tween_min;
  logic [FRAME_W-1:0]   tween_max;
  ease_mode_t           tween_ease;

  kti_out_t             expected_tweens[$];

  int                   mismatch_count = 0;
  int                   items_sent     = 0;
  int                   restarts_sent  = 0;
  int                   results_seen   = 0;
  int                   cfg_writes     = 0;
  int                   burst_left     = 0;
  int                   gap_max        = 3;
  int                   idle_cycles    = 0;

  // Receiver stall pattern state.
  int                   rx_mode        = 0;
  int                   rx_mode_left   = 0;
  int                   stall_left     = 0;

  keyframe_tween_interpolator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Easing factor for a curve parameter t in Q1.FRAC_BITS, one inclusive.
  function automatic logic [63:0] ease_factor(input logic [63:0] t, input ease_mode_t mode);
    logic [63:0] u;
    logic [63:0] v;
    case (mode)
      EASE_IN: return (t * t) >> FRAC_BITS;
      EASE_OUT: return (t * (2 * ONE_Q - t)) >> FRAC_BITS;
      EASE_IN_OUT: begin
        u = 2 * t;
        if (u < ONE_Q) return (u * u) >> (FRAC_BITS + 1);
        v = u - ONE_Q;
        return (ONE_Q + ((v * (2 * ONE_Q - v)) >> FRAC_BITS)) >> 1;
      end
      default: return t;
    endcase
  endfunction

  // Works out the result word of one request and updates the frame counter.
  function automatic kti_out_t predict_tween(input kti_in_t req);
    kti_out_t           res;
    logic [63:0]        t;
    logic [63:0]        f;
    logic signed [63:0] delta;
    logic signed [63:0] factor;
    logic signed [63:0] scaled;
    res.last = req.last_of_frame;
    if (req.req_type == REQ_RESTART) begin
      tween_frame = tween_min;
      res.value = '0;
      res.frame = tween_frame;
      return res;
    end
    res.frame = tween_frame;
    if (tween_max == 0 || tween_frame >= tween_max) begin
      t = ONE_Q;
    end else begin
      t = ({48'd0, tween_frame} << FRAC_BITS) / {48'd0, tween_max};
    end
    f = ease_factor(t, tween_ease);
    if (f > ONE_Q) f = ONE_Q;
    delta = $signed({{32{req.end_value[31]}}, req.end_value})
          - $signed({{32{req.start_value[31]}}, req.start_value});
    factor = $signed(f);
    // Arithmetic shift rounds toward minus infinity.
    scaled = (delta * factor) >>> FRAC_BITS;
    res.value = req.start_value + scaled[31:0];
    if (req.last_of_frame) begin
      if (tween_frame < tween_max) tween_frame = tween_frame + 1'b1;
      else tween_frame = tween_min;
    end
    return res;
  endfunction

  function automatic kti_in_t make_request(input logic req_type, input logic [31:0] start_v,
                                           input logic [31:0] end_v, input logic last);
    kti_in_t req;
    req.req_type      = req_type;
    req.start_value   = start_v;
    req.end_value     = end_v;
    req.last_of_frame = last;
    return req;
  endfunction

  // Component value: full range in four draws of ten, small values and extremes in three each.
  function automatic logic [31:0] rand_component();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
      7: return 32'h8000_0000;
      8: return 32'h7FFF_FFFF;
      default: return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
    endcase
  endfunction

  // Sends one request word in bursts with random gaps, and predicts its result.
  task automatic send_request(input kti_in_t req);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= req;
    do @(posedge clk); while (!in_ready);
    expected_tweens.insert(expected_tweens.size(), predict_tween(req));
    items_sent++;
    if (req.req_type == REQ_RESTART) restarts_sent++;
  endtask

  // Holds the request channel idle until every result has come and the unit settles.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_tweens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write of a group.
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_FRAME:   tween_min  = data;
      REG_MAX_FRAME:   tween_max  = data;
      REG_EASING_MODE: tween_ease = ease_mode_t'(data[1:0]);
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Register defaults, field extremes, restarts and the counter advancing.
  task automatic test_reset_defaults();
    send_request(make_request(REQ_INTERP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    send_request(make_request(REQ_INTERP, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    send_request(make_request(REQ_INTERP, 32'h0, 32'h7FFF_FFFF, 1'b1));
    send_request(make_request(REQ_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_request(make_request(REQ_RESTART, 32'h0, 32'h0, 1'b0));
  endtask

  // Every easing curve, on both sides of the in-out midpoint.
  task automatic test_easing_curves();
    drain_results();
    write_register(REG_MIN_FRAME, 16'd29);
    write_register(REG_MAX_FRAME, 16'd60);
    for (int m = 0; m < 4; m++) begin
      if (m != 0) drain_results();
      // Upper data bits are set at random; only the low two bits count.
      write_register(REG_EASING_MODE, {14'($urandom), m[1:0]});
      cfg_valid <= 1'b0;
      send_request(make_request(REQ_RESTART, $urandom, $urandom, 1'b0));
      send_request(make_request(REQ_INTERP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
      send_request(make_request(REQ_INTERP, 32'h7FFF_FFFF, 32'hFFFE_8000, 1'b1));
    end
  endtask

  // Saturated t: zero max_frame, frame past max_frame, ignored writes, wrap.
  task automatic test_frame_saturation();
    drain_results();
    write_register(REG_MIN_FRAME, 16'hFFFF);
    write_register(REG_MAX_FRAME, 16'h0);
    cfg_valid <= 1'b0;
    send_request(make_request(REQ_RESTART, 32'h0, 32'h0, 1'b0));
    send_request(make_request(REQ_INTERP, 32'h0001_0000, 32'hFFFF_0000, 1'b1));
    drain_results();
    write_register(REG_NONE, 16'hFFFF);
    write_register(REG_MAX_FRAME, 16'hFFFF);
    write_register(REG_EASING_MODE, {14'h3FFF, EASE_LINEAR});
    cfg_valid <= 1'b0;
    send_request(make_request(REQ_INTERP, 32'h8000_0000, 32'h0, 1'b1));
    drain_results();
    write_register(REG_MIN_FRAME, 16'd3);
    write_register(REG_MAX_FRAME, 16'd5);
    cfg_valid <= 1'b0;
    send_request(make_request(REQ_RESTART, 32'h0, 32'h0, 1'b1));
    for (int k = 0; k < 4; k++) begin
      send_request(make_request(REQ_INTERP, 32'hFFF0_0000, 32'h0010_0000, 1'b1));
    end
  endtask

  // Phases of random frames under random settings, draining between phases.
  task automatic test_random_traffic();
    int      phase_end;
    int      parts;
    int      pick;
    kti_in_t req;
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 9))
          0: write_register(REG_MIN_FRAME, 16'h0);
          1: write_register(REG_MIN_FRAME, 16'hFFFF);
          2, 3: write_register(REG_MIN_FRAME, 16'($urandom));
          default: write_register(REG_MIN_FRAME, 16'($urandom_range(0, 20)));
        endcase
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 19))
          0, 1: write_register(REG_MAX_FRAME, 16'h0);
          2: write_register(REG_MAX_FRAME, 16'd1);
          3, 4: write_register(REG_MAX_FRAME, 16'hFFFF);
          5, 6: write_register(REG_MAX_FRAME, 16'($urandom));
          7, 8, 9: write_register(REG_MAX_FRAME, 16'($urandom_range(41, 300)));
          default: write_register(REG_MAX_FRAME, 16'($urandom_range(1, 40)));
        endcase
      end
      if ($urandom_range(0, 2) != 0) write_register(REG_EASING_MODE, 16'($urandom));
      if ($urandom_range(0, 7) == 0) write_register(REG_NONE, 16'($urandom));
      cfg_valid <= 1'b0;
      case ($urandom_range(0, 3))
        0: gap_max = 0;
        1: gap_max = 2;
        2: gap_max = 10;
        default: gap_max = 70;
      endcase
      phase_end = items_sent + $urandom_range(20, 120);
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_request(make_request(REQ_RESTART, $urandom, $urandom, 1'($urandom)));
        end else if (pick < 12) begin
          // Stray component with a random end-of-frame flag.
          send_request(make_request(REQ_INTERP, $urandom, $urandom, 1'($urandom)));
        end else begin
          // One well-formed frame: one to four components, the last one flagged.
          parts = $urandom_range(1, 4);
          for (int k = 0; k < parts; k++) begin
            req = make_request(REQ_INTERP, rand_component(), rand_component(), k == parts - 1);
            if ($urandom_range(0, 4) == 0) req.end_value = req.start_value + 32'($urandom_range(0, 255));
            send_request(req);
          end
        end
      end
    end
  endtask

  // Compare each result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    kti_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_tweens.size() == 0) begin
        $error("unexpected result word: value %h frame %0d last %0b",
               out_word.value, out_word.frame, out_word.last);
        mismatch_count++;
      end else begin
        want = expected_tweens.pop_front();
        if (out_word.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, out_word.value);
          mismatch_count++;
        end
        if (out_word.frame !== want.frame) begin
          $error("frame: expected %0d, got %0d", want.frame, out_word.frame);
          mismatch_count++;
        end
        if (out_word.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_word.last);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver stalls: stretches with no stall, light stalls and long stalls.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(100, 600);
    end else begin
      rx_mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_mode != 0 && $urandom_range(0, 99) < ((rx_mode == 1) ? 20 : 60)) begin
      stall_left = $urandom_range(0, (rx_mode == 1) ? 4 : 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tween_frame = '0;
    tween_min   = '0;
    tween_max   = 16'd60;
    tween_ease  = EASE_LINEAR;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_easing_curves();
    test_frame_saturation();
    test_random_traffic();
    drain_results();
    $display("Sent %0d request words (%0d restarts) and checked %0d result words.",
             items_sent, restarts_sent, results_seen);
    $display("Made %0d register writes across all easing curves and frame ranges.",
             cfg_writes);
    if (mismatch_count == 0 && expected_tweens.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
